@@ src/pssm_pkg.sv @@
`timescale 1ns / 1ps
package pssm_pkg;
  localparam int POOL_SLOTS = 256;
  localparam int SLOT_W     = 8;
  localparam int CNT_W      = 9;
  localparam logic [CNT_W-1:0] POOL_FULL = 9'd256;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TOOBIG  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NONE    = 2'd3;

  localparam logic [1:0] LANE_HIGH = 2'd0;
  localparam logic [1:0] LANE_MID  = 2'd1;
  localparam logic [1:0] LANE_LOW  = 2'd2;

  localparam logic [1:0] PR_NORMAL = 2'd0;
  localparam logic [1:0] PR_WATCH  = 2'd1;
  localparam logic [1:0] PR_FULL   = 2'd2;

  localparam logic [1:0] REG_LIMIT = 2'd0;
  localparam logic [1:0] REG_WATCH = 2'd1;
  localparam logic [1:0] REG_FULLT = 2'd2;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_ENQ  = 2'd1;
  localparam logic [1:0] OP_DEQ  = 2'd2;

  typedef struct packed {
    logic       start;
    logic       rd;
    logic       commit;
    logic [1:0] op;
  } pssm_cmd_t;

  typedef struct packed {
    logic busy;
  } pssm_stat_t;

  function automatic logic [1:0] lane_of(input logic [1:0] prio);
    case (prio)
      2'd2:    lane_of = LANE_MID;
      2'd3:    lane_of = LANE_LOW;
      default: lane_of = LANE_HIGH;
    endcase
  endfunction
endpackage

@@ src/priority_slot_spool_manager_core.sv @@
`timescale 1ns / 1ps
// Slot pool manager with a free list and three priority lanes.
// s_axis: one command word per transfer, fields listed at the port.
//   mode 0 enqueues into the lane of its priority, mode 1 dequeues
//   the head of the highest nonempty lane.
// m_axis: one result word per command, fields listed at the port.
// cfg_we/cfg_index/cfg_data write payload_limit (0), watch_threshold (1)
// and full_threshold (2). The user must write them only while no command is
// in flight; the block itself does not enforce this. On accept (S_IDLE) the
// free ring entry and a lane head are registered, S_READ reads the entry
// store at that head, and S_COMMIT commits state and loads the result
// register. One command is in flight at a time; tready returns in the cycle
// after the commit, so a new command is taken only once the last has committed.
// If the receiver stalls, the result holds in the output register and
// the next command waits before its commit until the result is taken.
// Reset (rst, synchronous) empties all lanes, marks every slot free and
// reloads the register defaults; unwritten free ring entries read as
// their own index through a fill count, so no clearing pass is needed.
module priority_slot_spool_manager_core
  import pssm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mode[0], priority_req[2:1], payload_len[18:3], entry_data[50:19],
  // entry_kind[52:51]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], evicted[2], evicted_slot[10:3], slot_index[18:11],
  // sequence_res[50:19], out_data[82:51], out_kind[84:83],
  // out_priority[86:85], pressure[88:87], free_slots[97:89],
  // lane_depth[106:98]
  output logic [111:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  logic [15:0] payload_limit;
  logic [8:0]  watch_threshold, full_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_limit   <= 16'd1024;
      watch_threshold <= 9'd32;
      full_threshold  <= 9'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LIMIT: payload_limit   <= cfg_data;
        REG_WATCH: watch_threshold <= cfg_data[8:0];
        REG_FULLT: full_threshold  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  pssm_cmd_t  cmd;
  pssm_stat_t stat;

  pssm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_mode  (s_axis_tdata[0]),
    .out_busy (stat.busy),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  logic [1:0]  o_status, o_kind, o_prio, o_pressure;
  logic        o_evicted;
  logic [7:0]  o_evicted_slot, o_slot;
  logic [31:0] o_seq, o_data;
  logic [8:0]  o_free, o_depth;

  pssm_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .in_prio         (s_axis_tdata[2:1]),
    .in_len          (s_axis_tdata[18:3]),
    .in_data         (s_axis_tdata[50:19]),
    .in_kind         (s_axis_tdata[52:51]),
    .payload_limit   (payload_limit),
    .watch_threshold (watch_threshold),
    .full_threshold  (full_threshold),
    .out_take        (m_axis_tvalid && m_axis_tready),
    .stat            (stat),
    .out_valid       (m_axis_tvalid),
    .o_status        (o_status),
    .o_evicted       (o_evicted),
    .o_evicted_slot  (o_evicted_slot),
    .o_slot          (o_slot),
    .o_seq           (o_seq),
    .o_data          (o_data),
    .o_kind          (o_kind),
    .o_prio          (o_prio),
    .o_pressure      (o_pressure),
    .o_free          (o_free),
    .o_depth         (o_depth)
  );

  assign m_axis_tdata = {5'd0, o_depth, o_free, o_pressure, o_prio, o_kind, o_data,
                         o_seq, o_slot, o_evicted_slot, o_evicted, o_status};
endmodule

@@ src/pssm_ctrl.sv @@
`timescale 1ns / 1ps
module pssm_ctrl
  import pssm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_mode,
  input  logic       out_busy,
  output logic       in_ready,
  output pssm_cmd_t  cmd
);
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_READ   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state, state_next;
  logic [1:0] op, op_next;

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd.start  = 1'b0;
    cmd.rd     = 1'b0;
    cmd.commit = 1'b0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.start  = 1'b1;
          op_next    = in_mode ? OP_DEQ : OP_ENQ;
          state_next = S_READ;
        end
      end
      // entry store read at the lane head
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_COMMIT;
      end
      // commit only once the result register is free
      S_COMMIT: begin
        if (!out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    cmd.op = op_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_NONE;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end
endmodule

@@ src/pssm_dp.sv @@
`timescale 1ns / 1ps
module pssm_dp
  import pssm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  pssm_cmd_t   cmd,
  input  logic [1:0]  in_prio,
  input  logic [15:0] in_len,
  input  logic [31:0] in_data,
  input  logic [1:0]  in_kind,
  input  logic [15:0] payload_limit,
  input  logic [8:0]  watch_threshold,
  input  logic [8:0]  full_threshold,
  input  logic        out_take,
  output pssm_stat_t  stat,
  output logic        out_valid,
  output logic [1:0]  o_status,
  output logic        o_evicted,
  output logic [7:0]  o_evicted_slot,
  output logic [7:0]  o_slot,
  output logic [31:0] o_seq,
  output logic [31:0] o_data,
  output logic [1:0]  o_kind,
  output logic [1:0]  o_prio,
  output logic [1:0]  o_pressure,
  output logic [8:0]  o_free,
  output logic [8:0]  o_depth
);
  logic [SLOT_W-1:0] free_mem [POOL_SLOTS];
  logic [SLOT_W-1:0] lane_mem [3][POOL_SLOTS];
  logic [31:0]       word_mem [POOL_SLOTS];
  logic [1:0]        kind_mem [POOL_SLOTS];
  logic [1:0]        prio_mem [POOL_SLOTS];
  logic [31:0]       seq_mem  [POOL_SLOTS];

  logic [SLOT_W-1:0] free_rd, free_wr;
  logic [CNT_W-1:0]  free_cnt;
  // free_mem entries written so far, saturating; unwritten ones read as their index
  logic [CNT_W-1:0]  init_cnt;
  logic [SLOT_W-1:0] lane_rd [3];
  logic [SLOT_W-1:0] lane_wr [3];
  logic [CNT_W-1:0]  lane_cnt [3];
  logic [31:0]       seq_cnt;

  // per-item registers
  logic [1:0]        r_prio, r_kind, r_lane, r_srv;
  logic [15:0]       r_len;
  logic [31:0]       r_data;
  logic              r_any;
  logic [SLOT_W-1:0] free_q, lane_q;
  logic              free_hit;
  logic [31:0]       w_q, s_q;
  logic [1:0]        k_q, p_q;

  logic [1:0] srv_sel, rd_sel;
  logic       srv_any;
  always_comb begin
    srv_any = 1'b1;
    if (lane_cnt[LANE_HIGH] != '0)     srv_sel = LANE_HIGH;
    else if (lane_cnt[LANE_MID] != '0) srv_sel = LANE_MID;
    else if (lane_cnt[LANE_LOW] != '0) srv_sel = LANE_LOW;
    else begin
      srv_sel = LANE_LOW;
      srv_any = 1'b0;
    end
    // dequeue reads the served head, enqueue the low head for a possible eviction
    rd_sel = (cmd.op == OP_DEQ) ? srv_sel : LANE_LOW;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      r_prio   <= in_prio;
      r_kind   <= in_kind;
      r_len    <= in_len;
      r_data   <= in_data;
      r_lane   <= lane_of(in_prio);
      r_srv    <= srv_sel;
      r_any    <= srv_any;
      free_q   <= free_mem[free_rd];
      free_hit <= ({1'b0, free_rd} < init_cnt);
      lane_q   <= lane_mem[rd_sel][lane_rd[rd_sel]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      w_q <= word_mem[lane_q];
      k_q <= kind_mem[lane_q];
      p_q <= prio_mem[lane_q];
      s_q <= seq_mem[lane_q];
    end
  end

  logic              have, evict, deq_hit, do_enq, do_deq, free_push;
  logic [SLOT_W-1:0] slot;
  logic [1:0]        status, press;
  logic [CNT_W-1:0]  free_after, depth;
  logic [31:0]       seq_new;
  always_comb begin
    have       = 1'b0;
    evict      = 1'b0;
    slot       = '0;
    status     = ST_OK;
    free_after = free_cnt;
    depth      = '0;
    seq_new    = seq_cnt + 32'd1;
    deq_hit    = (cmd.op == OP_DEQ) && r_any;
    if (cmd.op == OP_DEQ) begin
      if (r_any) begin
        slot  = lane_q;
        depth = lane_cnt[r_srv] - 9'd1;
        if (free_cnt < POOL_FULL) free_after = free_cnt + 9'd1;
      end else begin
        status = ST_NONE;
      end
    end else begin
      depth = lane_cnt[r_lane];
      if (r_len >= payload_limit) begin
        status = ST_TOOBIG;
      end else if (free_cnt != '0) begin
        have       = 1'b1;
        slot       = free_hit ? free_q : free_rd;
        free_after = free_cnt - 9'd1;
        depth      = lane_cnt[r_lane] + 9'd1;
      end else if (lane_cnt[LANE_LOW] != '0) begin
        have  = 1'b1;
        evict = 1'b1;
        slot  = lane_q;
        // evicting into the low lane leaves its depth unchanged
        if (r_lane != LANE_LOW) depth = lane_cnt[r_lane] + 9'd1;
      end else begin
        status = ST_FULL;
      end
    end
    if (free_after <= full_threshold)       press = PR_FULL;
    else if (free_after <= watch_threshold) press = PR_WATCH;
    else                                    press = PR_NORMAL;
    do_enq    = cmd.commit && (cmd.op != OP_DEQ) && have;
    do_deq    = cmd.commit && deq_hit;
    free_push = do_deq && (free_cnt < POOL_FULL);
  end

  logic [2:0]        lane_pop, lane_push;
  logic [SLOT_W-1:0] lane_rd_next [3];
  logic [SLOT_W-1:0] lane_wr_next [3];
  logic [CNT_W-1:0]  lane_cnt_next [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lane_pop[i]  = (do_enq && evict && 2'(i) == LANE_LOW) || (do_deq && 2'(i) == r_srv);
      lane_push[i] = do_enq && 2'(i) == r_lane;
      lane_rd_next[i]  = lane_pop[i] ? lane_rd[i] + 8'd1 : lane_rd[i];
      lane_wr_next[i]  = lane_push[i] ? lane_wr[i] + 8'd1 : lane_wr[i];
      lane_cnt_next[i] = lane_cnt[i] + {8'd0, lane_push[i]} - {8'd0, lane_pop[i]};
    end
  end

  assign stat.busy = out_valid && !out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_rd   <= '0;
      free_wr   <= '0;
      free_cnt  <= POOL_FULL;
      init_cnt  <= '0;
      seq_cnt   <= '0;
      for (int i = 0; i < 3; i++) begin
        lane_rd[i]  <= '0;
        lane_wr[i]  <= '0;
        lane_cnt[i] <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        lane_rd[i]  <= lane_rd_next[i];
        lane_wr[i]  <= lane_wr_next[i];
        lane_cnt[i] <= lane_cnt_next[i];
      end
      if (cmd.commit) free_cnt <= free_after;
      if (do_enq) seq_cnt <= seq_new;
      if (do_enq && !evict) free_rd <= free_rd + 8'd1;
      if (free_push) begin
        free_wr <= free_wr + 8'd1;
        if (init_cnt != POOL_FULL) init_cnt <= init_cnt + 9'd1;
      end
      if (cmd.commit)    out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_enq) begin
      word_mem[slot] <= r_data;
      kind_mem[slot] <= r_kind;
      prio_mem[slot] <= r_prio;
      seq_mem[slot]  <= seq_new;
      lane_mem[r_lane][lane_wr[r_lane]] <= slot;
    end
    if (free_push) free_mem[free_wr] <= slot;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      o_status       <= status;
      o_evicted      <= evict;
      o_evicted_slot <= evict ? slot : '0;
      o_slot         <= slot;
      o_seq          <= deq_hit ? s_q : (have ? seq_new : '0);
      o_data         <= deq_hit ? w_q : '0;
      o_kind         <= deq_hit ? k_q : '0;
      o_prio         <= deq_hit ? p_q : '0;
      o_pressure     <= press;
      o_free         <= free_after;
      o_depth        <= depth;
    end
  end
endmodule

@@ src/pssm_checker.sv @@
`timescale 1ns / 1ps
module pssm_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");
  a_free_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[97:89] <= 9'd256)
    else $error("free count out of range");
  a_press: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[88:87] != 2'd3)
    else $error("bad pressure code");
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word taken while busy");
endmodule

bind priority_slot_spool_manager_core pssm_checker u_chk (.*);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb
  import pssm_pkg::*;
();

  typedef struct packed {
    logic [2:0]  pad;
    logic [1:0]  kind;
    logic [31:0] data;
    logic [15:0] plen;
    logic [1:0]  prio;
    logic        mode;
  } cmd_word_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic [8:0]  depth;
    logic [8:0]  free_n;
    logic [1:0]  pressure;
    logic [1:0]  oprio;
    logic [1:0]  okind;
    logic [31:0] odata;
    logic [31:0] seq;
    logic [7:0]  slot;
    logic [7:0]  ev_slot;
    logic        ev;
    logic [1:0]  status;
  } res_word_t;

  typedef struct {
    cmd_word_t cmd;
    logic      typed;
    res_word_t res;
  } dir_row_t;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;
  localparam int   LIMIT_CYC = 400000;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [55:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [111:0] m_axis_tdata;
  logic         cfg_we = 0;
  logic [1:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  priority_slot_spool_manager_core u_top (.*);

  always #4 clk = ~clk;

  // spool shadow state
  logic [15:0] sh_limit;
  logic [8:0]  sh_watch, sh_fullt;
  logic [7:0]  free_ring [256];
  logic [7:0]  free_rd, free_wr;
  int          free_cnt;
  logic [7:0]  lane_ring [3][256];
  logic [7:0]  lane_rd [3], lane_wr [3];
  int          lane_cnt [3];
  logic [31:0] slot_data [256], slot_seq [256];
  logic [1:0]  slot_kind [256], slot_prio [256];
  logic [31:0] seq_ctr;

  res_word_t   pending_res [$];
  int          errors = 0;
  int          stall_pct = 0, gap_pct = 0;
  int          items_sent = 0;
  int          cycles = 0;

  function automatic logic [1:0] lane_for(logic [1:0] p);
    return (p == 2'd3) ? LANE_LOW : (p == 2'd2) ? LANE_MID : LANE_HIGH;
  endfunction

  function automatic logic [1:0] pressure_for(int f);
    if (f <= sh_fullt) return PR_FULL;
    if (f <= sh_watch) return PR_WATCH;
    return PR_NORMAL;
  endfunction

  function automatic void spool_reset();
    sh_limit = 16'd1024; sh_watch = 9'd32; sh_fullt = 9'd8;
    for (int i = 0; i < 256; i++) free_ring[i] = i[7:0];
    free_rd = 0; free_wr = 0; free_cnt = 256; seq_ctr = 0;
    for (int l = 0; l < 3; l++) begin
      lane_rd[l] = 0; lane_wr[l] = 0; lane_cnt[l] = 0;
    end
  endfunction

  function automatic res_word_t spool_step(cmd_word_t c);
    res_word_t r;
    logic [1:0] ln;
    logic [7:0] s;
    logic have;
    r = '0;
    have = 0;
    if (c.mode == MODE_ENQ) begin
      ln = lane_for(c.prio);
      if (c.plen >= sh_limit) r.status = ST_TOOBIG;
      else if (free_cnt > 0) begin
        s = free_ring[free_rd]; free_rd++; free_cnt--; have = 1;
      end else if (lane_cnt[LANE_LOW] > 0) begin
        s = lane_ring[LANE_LOW][lane_rd[LANE_LOW]];
        lane_rd[LANE_LOW]++; lane_cnt[LANE_LOW]--;
        r.ev = 1; r.ev_slot = s; have = 1;
      end else r.status = ST_FULL;
      if (have) begin
        seq_ctr++;
        r.slot = s; r.seq = seq_ctr;
        slot_data[s] = c.data; slot_kind[s] = c.kind;
        slot_prio[s] = c.prio; slot_seq[s] = seq_ctr;
        lane_ring[ln][lane_wr[ln]] = s; lane_wr[ln]++; lane_cnt[ln]++;
      end
      r.depth = 9'(lane_cnt[ln]);
    end else begin
      r.status = ST_NONE;
      for (int l = 0; l < 3; l++) begin
        if (r.status == ST_NONE && lane_cnt[l] > 0) begin
          s = lane_ring[l][lane_rd[l]]; lane_rd[l]++; lane_cnt[l]--;
          r.status = ST_OK; r.slot = s; r.seq = slot_seq[s];
          r.odata = slot_data[s]; r.okind = slot_kind[s]; r.oprio = slot_prio[s];
          r.depth = 9'(lane_cnt[l]);
          free_ring[free_wr] = s; free_wr++; free_cnt++;
        end
      end
    end
    r.pressure = pressure_for(free_cnt);
    r.free_n = 9'(free_cnt);
    return r;
  endfunction

  // idle profile rotates every 50 words
  function automatic void pick_idling();
    case ((items_sent / 50) % 4)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 49; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 49; end
      default: begin gap_pct = 37; stall_pct = 37; end
    endcase
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYC) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    res_word_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_res.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", got);
      end else begin
        want = pending_res.pop_front();
        if (got[106:0] !== want[106:0]) begin
          errors++;
          if (errors <= 10) $display("mismatch exp %h got %h", want, got);
        end
      end
    end
  end

  task automatic send_word(cmd_word_t c, logic typed, res_word_t tres);
    res_word_t p;
    pick_idling();
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= c;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    p = spool_step(c);
    pending_res.push_back(typed ? tres : p);
    items_sent++;
  endtask

  task automatic drain_idle();
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_LIMIT: sh_limit = v;
      REG_WATCH: sh_watch = v[8:0];
      default:   sh_fullt = v[8:0];
    endcase
    @(posedge clk);
  endtask

  task automatic random_phase(int n, int enq_pct, int prio_lo, int prio_hi,
                              logic [15:0] plen_max);
    cmd_word_t c;
    for (int i = 0; i < n; i++) begin
      c = '0;
      c.mode = ($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
      c.prio = 2'($urandom_range(prio_hi, prio_lo));
      c.plen = ($urandom_range(19) == 0) ? 16'($urandom_range(65535))
                                         : 16'($urandom_range(plen_max));
      c.data = $urandom;
      c.kind = 2'($urandom_range(3));
      send_word(c, 0, '0);
    end
  endtask

  function automatic cmd_word_t mk(logic m, logic [1:0] p, logic [15:0] l,
                                   logic [31:0] d, logic [1:0] k);
    cmd_word_t c;
    c = '0;
    c.mode = m; c.prio = p; c.plen = l; c.data = d; c.kind = k;
    return c;
  endfunction

  initial begin
    dir_row_t rows [$];
    dir_row_t row;
    res_word_t r0;
    spool_reset();
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // empty dequeue after reset
    r0 = '0; r0.status = ST_NONE; r0.pressure = PR_NORMAL; r0.free_n = 256;
    row.cmd = mk(MODE_DEQ, 2'd0, 16'd0, 32'd0, 2'd0); row.typed = 1; row.res = r0;
    rows.push_back(row);
    // oversize enqueue drops with no state change
    r0 = '0; r0.status = ST_TOOBIG; r0.pressure = PR_NORMAL; r0.free_n = 256;
    row.cmd = mk(MODE_ENQ, 2'd3, 16'hFFFF, 32'hFFFF_FFFF, 2'd3); row.res = r0;
    rows.push_back(row);
    r0.free_n = 256;
    row.cmd = mk(MODE_ENQ, 2'd0, 16'd1024, 32'd0, 2'd0); row.res = r0;
    rows.push_back(row);
    row.typed = 0; row.res = '0;
    row.cmd = mk(MODE_ENQ, 2'd3, 16'd1023, 32'hFFFF_FFFF, 2'd3); rows.push_back(row);
    row.cmd = mk(MODE_ENQ, 2'd2, 16'd0, 32'h0, 2'd2); rows.push_back(row);
    row.cmd = mk(MODE_ENQ, 2'd1, 16'd5, 32'hA5A5_5A5A, 2'd1); rows.push_back(row);
    row.cmd = mk(MODE_ENQ, 2'd0, 16'd7, 32'h1234_5678, 2'd0); rows.push_back(row);
    for (int i = 0; i < 5; i++) begin
      row.cmd = mk(MODE_DEQ, 2'(i), 16'hFFFF, 32'hFFFF_FFFF, 2'd3); rows.push_back(row);
    end
    foreach (rows[i]) send_word(rows[i].cmd, rows[i].typed, rows[i].res);
    drain_idle();

    // fill the pool without low-lane entries: pool-full drops
    write_reg(REG_LIMIT, 16'hFFFF); write_reg(REG_WATCH, 16'd256);
    write_reg(REG_FULLT, 16'd0);
    random_phase(270, 100, 0, 2, 16'hFFFE);
    drain_idle();

    write_reg(REG_LIMIT, 16'd1024); write_reg(REG_WATCH, 16'd32);
    write_reg(REG_FULLT, 16'd8);
    random_phase(40, 40, 3, 3, 16'd1100);
    drain_idle();

    // refill with low-lane traffic to force evictions
    write_reg(REG_LIMIT, 16'd40000); write_reg(REG_WATCH, 16'd200);
    write_reg(REG_FULLT, 16'd100);
    random_phase(60, 85, 1, 3, 16'd41000);
    drain_idle();

    // zero limit drops every enqueue
    write_reg(REG_LIMIT, 16'd0); write_reg(REG_WATCH, 16'd0);
    write_reg(REG_FULLT, 16'd256);
    random_phase(15, 50, 0, 3, 16'hFFFF);
    drain_idle();

    write_reg(REG_LIMIT, 16'd1); write_reg(REG_WATCH, 16'h1FF);
    write_reg(REG_FULLT, 16'd5);
    random_phase(20, 30, 0, 3, 16'd1);
    drain_idle();

    if (errors == 0 && pending_res.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
